### hw/rtl/glu_pkg.sv
// glu_pkg: shared types and constants for the gcd / lcm unit
// payload structs for both channels and the sequencer state encoding
// no dependencies
package glu_pkg;

    // field widths fixed by the channel format
    localparam int unsigned VALUE_WIDTH    = 32;
    localparam int unsigned MULTIPLE_WIDTH = 64;

    // default number of significant operand bits
    localparam int unsigned OPERAND_WIDTH_DEF = 32;

    // input transfer payload
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] first_value;
        logic [VALUE_WIDTH-1:0] second_value;
    } in_t;

    // result transfer payload
    typedef struct packed {
        logic [VALUE_WIDTH-1:0]    divisor_result;
        logic [MULTIPLE_WIDTH-1:0] multiple_result;
        logic                      input_error;
    } out_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } state_t;

endpackage

### hw/rtl/gcd_lcm_unit_top.sv
// gcd_lcm_unit_top: greatest common divisor and least common multiple of two operands
// one shared add/subtract unit driven by a small sequencer (binary gcd, divide, multiply)
// depends on glu_pkg
//
// Usage: an operand pair is taken on the s_ channel (s_valid/s_ready, payload s_data)
// and one result leaves on the m_ channel (m_valid/m_ready, payload m_data).
// Operand bits at or above OPERAND_WIDTH (W) are ignored. A zero operand gives
// input_error = 1 with both numeric results 0.
// Each item goes through three phases on the one W+1 bit adder/subtractor:
//   binary gcd: one shift, swap or subtract per cycle; a subtract is always followed
//   by a shift and a swap by a subtract
//   division first / gcd: restoring, one quotient bit per cycle
//   multiply quotient * second: shift and add, one bit per cycle
// Only the gcd phase varies in length with the operands, so it sets the spread from
// accept to result valid; a zero operand skips all three phases.
// s_ready is high only while the sequencer is idle, so one item is in work at a time.
// The result sits in an output register; the sequencer takes the next item while it
// waits. If the receiver still holds an older result when a new one is finished,
// the sequencer waits until that result is transferred.
// aresetn (synchronous, active low) returns the sequencer to idle and drops m_valid.
module gcd_lcm_unit_top #(
    parameter int unsigned OPERAND_WIDTH = glu_pkg::OPERAND_WIDTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  glu_pkg::in_t s_data,
    output logic         m_valid,
    input  logic         m_ready,
    output glu_pkg::out_t m_data
);
    import glu_pkg::*;

    localparam int unsigned W  = OPERAND_WIDTH;
    localparam int unsigned CW = (W > 1) ? $clog2(W) : 1;
    localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

    // sequencer and datapath registers
    state_t        state_reg, state_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  first_reg, first_next;
    logic [W-1:0]  second_reg, second_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  g_reg, g_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quot_reg, quot_next;
    logic [2*W-1:0] prod_reg, prod_next;
    logic          err_reg, err_next;
    logic          m_valid_reg, m_valid_next;
    out_t          out_reg, out_next;

    // shared adder/subtractor
    logic [W:0]    alu_x;
    logic [W:0]    alu_y;
    logic          alu_sub;
    logic [W:0]    alu_res;

    // masked operands at the input
    logic [W-1:0]  in_first;
    logic [W-1:0]  in_second;
    logic          qbit;

    assign in_first  = s_data.first_value[W-1:0];
    assign in_second = s_data.second_value[W-1:0];

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // operand selection for the shared unit
    always_comb begin
        alu_x   = {1'b0, a_reg};
        alu_y   = {1'b0, b_reg};
        alu_sub = 1'b1;
        case (state_reg)
            ST_DIV: begin
                alu_x = {rem_reg, quot_reg[W-1]};
                alu_y = {1'b0, g_reg};
            end
            ST_MUL: begin
                alu_x   = {1'b0, prod_reg[2*W-1:W]};
                alu_y   = {1'b0, second_reg};
                alu_sub = 1'b0;
            end
            default: begin
                alu_x = {1'b0, a_reg};
                alu_y = {1'b0, b_reg};
            end
        endcase
        alu_res = alu_sub ? (alu_x - alu_y) : (alu_x + alu_y);
    end

    // next state and datapath updates
    always_comb begin
        state_next   = state_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        k_next       = k_reg;
        cnt_next     = cnt_reg;
        g_next       = g_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        prod_next    = prod_reg;
        err_next     = err_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        qbit         = !alu_res[W];

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (in_first == '0 || in_second == '0) begin
                        err_next   = 1'b1;
                        g_next     = '0;
                        prod_next  = '0;
                        state_next = ST_DONE;
                    end else begin
                        err_next    = 1'b0;
                        a_next      = in_first;
                        b_next      = in_second;
                        first_next  = in_first;
                        second_next = in_second;
                        k_next      = '0;
                        state_next  = ST_GCD;
                    end
                end
            end
            // binary gcd: one shift, swap or subtract per cycle
            ST_GCD: begin
                if (alu_res == '0) begin
                    g_next     = a_reg << k_reg;
                    rem_next   = '0;
                    quot_next  = first_reg;
                    cnt_next   = CNT_LAST;
                    state_next = ST_DIV;
                end else if (!a_reg[0] && !b_reg[0]) begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + CW'(1);
                end else if (!a_reg[0]) begin
                    a_next = a_reg >> 1;
                end else if (!b_reg[0]) begin
                    b_next = b_reg >> 1;
                end else if (alu_res[W]) begin
                    // a below b: swap so the subtract stays positive
                    a_next = b_reg;
                    b_next = a_reg;
                end else begin
                    a_next = alu_res[W-1:0];
                end
            end
            // restoring division of first by gcd, one quotient bit per cycle
            ST_DIV: begin
                if (qbit) begin
                    rem_next = alu_res[W-1:0];
                end else begin
                    rem_next = alu_x[W-1:0];
                end
                quot_next = {quot_reg[W-2:0], qbit};
                if (cnt_reg == '0) begin
                    prod_next  = {{W{1'b0}}, quot_reg[W-2:0], qbit};
                    cnt_next   = CNT_LAST;
                    state_next = ST_MUL;
                end else begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            // shift and add multiply of quotient by second
            ST_MUL: begin
                if (prod_reg[0]) begin
                    prod_next = {alu_res, prod_reg[W-1:1]};
                end else begin
                    prod_next = {1'b0, prod_reg[2*W-1:W], prod_reg[W-1:1]};
                end
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            // hand the result to the output register once it is free
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.divisor_result  = VALUE_WIDTH'(g_reg);
                    out_next.multiple_result = MULTIPLE_WIDTH'(prod_reg);
                    out_next.input_error     = err_reg;
                    m_valid_next             = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        first_reg  <= first_next;
        second_reg <= second_next;
        k_reg      <= k_next;
        cnt_reg    <= cnt_next;
        g_reg      <= g_next;
        rem_reg    <= rem_next;
        quot_reg   <= quot_next;
        prod_reg   <= prod_next;
        err_reg    <= err_next;
        out_reg    <= out_next;
    end

endmodule
